FILE: design/emc_pkg.sv
// ============================================================================
// emc_pkg
// Shared widths, configuration register codes and pipeline payload types
// for the ellipse mask classifier.
// ============================================================================
package emc_pkg;

  // geometry limits and fixed-point format
  localparam int MAX_DIM    = 4096;
  localparam int FRAC_BITS  = 4;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int AXIS_W     = 16;
  localparam int COLOR_W    = 32;

  // offset magnitude stays below the image size for pixels inside the image
  localparam int D_W        = $clog2(MAX_DIM);
  // doubled axis plus thickness
  localparam int AX_W       = AXIS_W + 2;
  localparam int SQ_W       = 2 * AX_W;
  localparam int HALF_W     = SQ_W / 2;
  localparam int DSQ_W      = 2 * D_W;
  localparam int XP_W       = DSQ_W + HALF_W;
  localparam int ABP_W      = SQ_W + HALF_W;
  localparam int XB_W       = DSQ_W + SQ_W;
  localparam int RHS_W      = 2 * SQ_W;

  // stream packing
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAINT  = 2 * COORD_W;
  localparam int OUT_COLOR  = OUT_PAINT + 1;
  localparam int OUT_USED_W = OUT_COLOR + COLOR_W;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_AXIS_A = 3'd2,
    REG_AXIS_B = 3'd3,
    REG_THICK  = 3'd4,
    REG_MODE   = 3'd5,
    REG_COLOR  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [AXIS_W-1:0]  axis_a;
    logic [AXIS_W-1:0]  axis_b;
    logic [AXIS_W-1:0]  thick;
    logic               ring;
    logic [COLOR_W-1:0] color;
  } cfg_t;

  // after offsets and axes
  typedef struct packed {
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic                    in_img;
    logic                    ring;
    logic [D_W-1:0]          dx;
    logic [D_W-1:0]          dy;
    logic [1:0][AX_W-1:0]    ax;
    logic [1:0][AX_W-1:0]    by;
  } prep_t;

  // after squaring
  typedef struct packed {
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic                    in_img;
    logic                    ring;
    logic [DSQ_W-1:0]        dx2;
    logic [DSQ_W-1:0]        dy2;
    logic [1:0][SQ_W-1:0]    asq;
    logic [1:0][SQ_W-1:0]    bsq;
  } sq_t;

  // partial products of one ellipse test
  typedef struct packed {
    logic [XP_W-1:0]  xb_lo;
    logic [XP_W-1:0]  xb_hi;
    logic [XP_W-1:0]  ya_lo;
    logic [XP_W-1:0]  ya_hi;
    logic [ABP_W-1:0] ab_lo;
    logic [ABP_W-1:0] ab_hi;
  } ell_prod_t;

  typedef struct packed {
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic                 in_img;
    logic                 ring;
    ell_prod_t [1:0]      e;
  } prod_t;

  // after partial product recombination
  typedef struct packed {
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic                    in_img;
    logic                    ring;
    logic [1:0][XB_W-1:0]    xb;
    logic [1:0][XB_W-1:0]    ya;
    logic [1:0][RHS_W-1:0]   rhs;
  } sum_t;

endpackage

FILE: design/emc_prep.sv
// ============================================================================
// emc_prep
// First pipeline stage: bounds check, center offsets in half pixels and
// the doubled ellipse axes for the selected drawing mode.
// ============================================================================
module emc_prep import emc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  output logic               out_valid,
  input  logic               out_ready,
  output prep_t              out_data
);

  logic [DIM_W-1:0]  w_sat;
  logic [DIM_W-1:0]  h_sat;
  logic [DIM_W-1:0]  tx;
  logic [DIM_W-1:0]  ty;
  logic [DIM_W-1:0]  ddx;
  logic [DIM_W-1:0]  ddy;
  logic [AX_W-1:0]   a2x;
  logic [AX_W-1:0]   b2x;
  logic [AX_W-1:0]   tk;
  logic [AX_W-1:0]   a_in;
  logic [AX_W-1:0]   b_in;
  prep_t             nxt;

  assign in_ready = !out_valid || out_ready;

  // saturate image size, offsets of the pixel center from the image center
  always_comb begin
    w_sat = (cfg.width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.width;
    h_sat = (cfg.height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.height;
    tx    = {in_x, 1'b1};
    ty    = {in_y, 1'b1};
    ddx   = (tx >= w_sat) ? tx - w_sat : w_sat - tx;
    ddy   = (ty >= h_sat) ? ty - h_sat : h_sat - ty;
  end

  // doubled axes, inner ring axes by magnitude, outer ring axes
  always_comb begin
    a2x  = {1'b0, cfg.axis_a, 1'b0};
    b2x  = {1'b0, cfg.axis_b, 1'b0};
    tk   = AX_W'(cfg.thick);
    a_in = (a2x >= tk) ? a2x - tk : tk - a2x;
    b_in = (b2x >= tk) ? b2x - tk : tk - b2x;

    nxt.px     = in_x;
    nxt.py     = in_y;
    nxt.in_img = (DIM_W'(in_x) < w_sat) && (DIM_W'(in_y) < h_sat);
    nxt.ring   = cfg.ring;
    nxt.dx     = ddx[D_W-1:0];
    nxt.dy     = ddy[D_W-1:0];
    nxt.ax[0]  = cfg.ring ? a_in : a2x;
    nxt.by[0]  = cfg.ring ? b_in : b2x;
    nxt.ax[1]  = a2x + tk;
    nxt.by[1]  = b2x + tk;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

FILE: design/emc_mult.sv
// ============================================================================
// emc_mult
// Two multiplier stages: squares of offsets and axes, then the partial
// products of both cross-multiplied ellipse tests, split at half width.
// ============================================================================
module emc_mult import emc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  prep_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t out_data
);

  logic  sq_valid;
  logic  sq_ready;
  sq_t   sq;
  sq_t   sq_nxt;
  prod_t pr_nxt;

  assign sq_ready = !out_valid || out_ready;
  assign in_ready = !sq_valid || sq_ready;

  // squares
  always_comb begin
    sq_nxt.px     = in_data.px;
    sq_nxt.py     = in_data.py;
    sq_nxt.in_img = in_data.in_img;
    sq_nxt.ring   = in_data.ring;
    sq_nxt.dx2    = DSQ_W'(in_data.dx) * DSQ_W'(in_data.dx);
    sq_nxt.dy2    = DSQ_W'(in_data.dy) * DSQ_W'(in_data.dy);
    for (int k = 0; k < 2; k++) begin
      sq_nxt.asq[k] = SQ_W'(in_data.ax[k]) * SQ_W'(in_data.ax[k]);
      sq_nxt.bsq[k] = SQ_W'(in_data.by[k]) * SQ_W'(in_data.by[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (in_ready) begin
      sq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sq <= sq_nxt;
    end
  end

  // partial products, each operand cut into low and high halves
  always_comb begin
    pr_nxt.px     = sq.px;
    pr_nxt.py     = sq.py;
    pr_nxt.in_img = sq.in_img;
    pr_nxt.ring   = sq.ring;
    for (int k = 0; k < 2; k++) begin
      pr_nxt.e[k].xb_lo = XP_W'(sq.dx2) * XP_W'(sq.bsq[k][HALF_W-1:0]);
      pr_nxt.e[k].xb_hi = XP_W'(sq.dx2) * XP_W'(sq.bsq[k][SQ_W-1:HALF_W]);
      pr_nxt.e[k].ya_lo = XP_W'(sq.dy2) * XP_W'(sq.asq[k][HALF_W-1:0]);
      pr_nxt.e[k].ya_hi = XP_W'(sq.dy2) * XP_W'(sq.asq[k][SQ_W-1:HALF_W]);
      pr_nxt.e[k].ab_lo = ABP_W'(sq.asq[k]) * ABP_W'(sq.bsq[k][HALF_W-1:0]);
      pr_nxt.e[k].ab_hi = ABP_W'(sq.asq[k]) * ABP_W'(sq.bsq[k][SQ_W-1:HALF_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sq_ready) begin
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ready && sq_valid) begin
      out_data <= pr_nxt;
    end
  end

endmodule

FILE: design/emc_cmp.sv
// ============================================================================
// emc_cmp
// Recombines the partial products, compares both sides of each ellipse
// test and registers the classified pixel as the output stage.
// ============================================================================
module emc_cmp import emc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [COLOR_W-1:0] color,
  input  logic               in_valid,
  output logic               in_ready,
  input  prod_t              in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic               paint,
  output logic [COLOR_W-1:0] color_out
);

  logic             sm_valid;
  logic             sm_ready;
  sum_t             sm;
  sum_t             sm_nxt;
  logic [RHS_W-1:0] lhs [2];
  logic [1:0]       le;
  logic [1:0]       ge;
  logic             paint_nxt;

  assign sm_ready = !out_valid || out_ready;
  assign in_ready = !sm_valid || sm_ready;

  // rebuild full products from the halves
  always_comb begin
    sm_nxt.px     = in_data.px;
    sm_nxt.py     = in_data.py;
    sm_nxt.in_img = in_data.in_img;
    sm_nxt.ring   = in_data.ring;
    for (int k = 0; k < 2; k++) begin
      sm_nxt.xb[k]  = XB_W'(in_data.e[k].xb_lo)
                      + (XB_W'(in_data.e[k].xb_hi) << HALF_W);
      sm_nxt.ya[k]  = XB_W'(in_data.e[k].ya_lo)
                      + (XB_W'(in_data.e[k].ya_hi) << HALF_W);
      sm_nxt.rhs[k] = RHS_W'(in_data.e[k].ab_lo)
                      + (RHS_W'(in_data.e[k].ab_hi) << HALF_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
    end else if (in_ready) begin
      sm_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sm <= sm_nxt;
    end
  end

  // left side carries the fractional scale of both squared offsets
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      lhs[k] = (RHS_W'(sm.xb[k]) + RHS_W'(sm.ya[k])) << (2 * FRAC_BITS);
      le[k]  = lhs[k] <= sm.rhs[k];
      ge[k]  = lhs[k] >= sm.rhs[k];
    end
    // ring: on or outside the inner ellipse and on or inside the outer one
    paint_nxt = sm.in_img && (sm.ring ? (ge[0] && le[1]) : le[0]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sm_ready) begin
      out_valid <= sm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sm_ready && sm_valid) begin
      out_x     <= sm.px;
      out_y     <= sm.py;
      paint     <= paint_nxt;
      color_out <= paint_nxt ? color : '0;
    end
  end

endmodule

FILE: design/ellipse_mask_classifier_core.sv
// ============================================================================
// ellipse_mask_classifier_core
// Paints pixels inside a filled ellipse or an outline ring centered in the
// image, one pixel coordinate per stream transaction.
// ============================================================================
// The core takes one pixel per clock while the output is not stalled and
// returns one classified pixel for each, in order. The pipeline stages
// are offsets and axes, squares, partial products, product recombination,
// then the exact comparison into the output register. Every stage holds
// its item under back-pressure and empty stages fill up, so input is still
// taken while a result waits at the output. The user must write registers
// through the cfg port only while no pixel is in flight; the core does not
// enforce this. A pixel accepted the cycle after a write already sees it.
module ellipse_mask_classifier_core import emc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // pixel input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // pixel_x[11:0], pixel_y[23:12]
  // classified pixel stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_x[11:0], out_y[23:12], paint[24], color_out[56:25], zero[63:57]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t               cfg;
  logic               pr_valid;
  logic               pr_ready;
  prep_t              pr_data;
  logic               mu_valid;
  logic               mu_ready;
  prod_t              mu_data;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               paint;
  logic [COLOR_W-1:0] color_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= DIM_W'(64);
      cfg.height <= DIM_W'(64);
      cfg.axis_a <= AXIS_W'(512);
      cfg.axis_b <= AXIS_W'(512);
      cfg.thick  <= AXIS_W'(16);
      cfg.ring   <= 1'b0;
      cfg.color  <= '1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_WIDTH:  cfg.width  <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: cfg.height <= cfg_wdata[DIM_W-1:0];
        REG_AXIS_A: cfg.axis_a <= cfg_wdata[AXIS_W-1:0];
        REG_AXIS_B: cfg.axis_b <= cfg_wdata[AXIS_W-1:0];
        REG_THICK:  cfg.thick  <= cfg_wdata[AXIS_W-1:0];
        REG_MODE:   cfg.ring   <= cfg_wdata[0];
        REG_COLOR:  cfg.color  <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // offsets and axes
  emc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_x      (s_axis_tdata[COORD_W-1:0]),
    .in_y      (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .out_valid (pr_valid),
    .out_ready (pr_ready),
    .out_data  (pr_data)
  );

  // squares and partial products
  emc_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pr_valid),
    .in_ready  (pr_ready),
    .in_data   (pr_data),
    .out_valid (mu_valid),
    .out_ready (mu_ready),
    .out_data  (mu_data)
  );

  // recombination, comparison and output register
  emc_cmp u_cmp (
    .clk       (clk),
    .rst       (rst),
    .color     (cfg.color),
    .in_valid  (mu_valid),
    .in_ready  (mu_ready),
    .in_data   (mu_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (out_x),
    .out_y     (out_y),
    .paint     (paint),
    .color_out (color_out)
  );

  assign m_axis_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), color_out, paint, out_y, out_x};

endmodule

FILE: design/emc_checker.sv
// ============================================================================
// emc_checker
// Port-level checks of the classifier: output stream stability, color of
// unpainted pixels, reset behavior and no result without an accepted pixel.
// ============================================================================
module emc_checker import emc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int DEPTH   = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] inflight;
  logic [CNT_W-1:0] inflight_next;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // pixels accepted but not yet delivered
  always_comb begin
    inflight_next = inflight + CNT_W'(in_acc) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  // a stalled result keeps its valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

  // a stalled result keeps its data
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed under stall");

  // unpainted pixels carry no color
  a_unpainted_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[OUT_PAINT] |->
      m_axis_tdata[OUT_COLOR+COLOR_W-1:OUT_COLOR] == '0)
    else $error("color on an unpainted pixel");

  // no result without an accepted pixel in flight
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> inflight != '0)
    else $error("result with no pixel in flight");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind ellipse_mask_classifier_core emc_checker u_emc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
